/* hdl/assert_macros.svh */
// assertion macros for the rtl files, included by the scan sequencer

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising clock edge, skipped while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// property checked at every rising clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_ALWAYS(label, clk, prop)

`endif

`endif

/* hdl/ipsf_pkg.sv */
// types, constants and helpers of the ipv4 prefix set filter
`timescale 1ns / 1ps

package ipsf_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W      = 32;
   localparam int LEN_W       = 6;
   localparam int STATUS_W    = 3;
   localparam int FULL_LENGTH = 32;

   localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   // action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_CHECK  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_CHECKED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_STORED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  prefix_length;
      logic              is_ipv4;
   } req_type;

   typedef struct packed {
      logic                matched;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [LEN_W-1:0]  bits;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

   // top len bits set; any length of 32 or more gives all ones
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      prefix_mask = ~(ALL_ONES >> len);
   endfunction

endpackage

/* hdl/ipv4_prefix_set_filter.sv */
// top level of the ipv4 prefix set filter
`timescale 1ns / 1ps

// ipv4 prefix set filter: a table of up to 64 cidr prefixes in one memory.
// a beat is taken when start is high and busy is low. action insert masks
// the address to prefix_length and stores it unless an entry with the same
// start address exists (duplicate) or the table is full; lengths above 32
// are refused as invalid. action check reports whether any stored prefix
// covers the address; a non-ipv4 check never matches.
// exactly one result beat follows each request: rsp_valid is high for one
// cycle and the receiver cannot stall it, so it must take the beat then.
// timing: the entries are read from memory one per cycle, so an item takes
// longer the more entries are stored, and ends sooner when a check hits or
// an insert finds a duplicate early; an invalid insert, a non-ipv4 check or
// any item on an empty table answers in the cycle after it is taken.
// busy falls as the result beat appears, and a new request may be taken in
// that same cycle. the table is cleared only by reset of the fill count;
// no clearing pass is needed since entries above the count are never read.

module ipv4_prefix_set_filter (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ipsf_pkg::req_type req_item,
   output logic              rsp_valid,
   output ipsf_pkg::rsp_type rsp_item
);

   ipsf_pkg::ram_wr_type ram_wr;
   ipsf_pkg::ram_rd_type ram_rd;
   ipsf_pkg::entry_type  ram_rd_data;

   // sequencer: scan, compare and write back
   ipsf_scan_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .ram_wr      (ram_wr),
      .ram_rd      (ram_rd),
      .ram_rd_data (ram_rd_data)
   );

   // entry store: base and length per entry, with a registered read port
   ipsf_entry_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

endmodule

/* hdl/ipsf_entry_ram.sv */
// prefix table memory, one write port and one registered read port
`timescale 1ns / 1ps

module ipsf_entry_ram (
   input  logic                clock,
   input  ipsf_pkg::ram_wr_type wr,
   input  ipsf_pkg::ram_rd_type rd,
   output ipsf_pkg::entry_type  rd_data
);

   ipsf_pkg::entry_type mem [ipsf_pkg::MAX_ENTRIES];
   ipsf_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/ipsf_scan_ctrl.sv */
// sequencer: scans the stored entries and decides each item's result
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipsf_scan_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ipsf_pkg::req_type    req_item,
   output logic                 rsp_valid,
   output ipsf_pkg::rsp_type    rsp_item,
   output ipsf_pkg::ram_wr_type ram_wr,
   output ipsf_pkg::ram_rd_type ram_rd,
   input  ipsf_pkg::entry_type  ram_rd_data
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                             state_ff, state_in;
   ipsf_pkg::req_type                req_ff, req_in;
   logic [ipsf_pkg::ADDR_W-1:0]      base_ff, base_in;
   logic [ipsf_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [ipsf_pkg::CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                             rd_pend_ff, rd_pend_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ipsf_pkg::rsp_type                rsp_ff, rsp_in;

   logic                             issue;
   logic                             hit;
   logic [ipsf_pkg::ADDR_W-1:0]      start_base;
   logic                             table_full;

   assign start_base = req_item.address & ipsf_pkg::prefix_mask(req_item.prefix_length);
   assign issue      = (state_ff == S_SCAN) && (rd_idx_ff < count_ff);
   assign table_full = (count_ff == ipsf_pkg::CNT_W'(ipsf_pkg::MAX_ENTRIES));

   // compare of the entry read in the previous cycle
   always_comb begin
      if (req_ff.action == ipsf_pkg::ACT_CHECK) begin
         hit = ((ram_rd_data.base ^ req_ff.address)
                & ipsf_pkg::prefix_mask(ram_rd_data.bits)) == '0;
      end else begin
         hit = (ram_rd_data.base == base_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      base_in      = base_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_rd.en    = issue;
      ram_rd.addr  = rd_idx_ff[ipsf_pkg::IDX_W-1:0];
      ram_wr.we    = 1'b0;
      ram_wr.addr  = count_ff[ipsf_pkg::IDX_W-1:0];
      ram_wr.data  = '{base: base_ff, bits: req_ff.prefix_length};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in    = req_item;
               base_in   = start_base;
               rd_idx_in = '0;
               if (req_item.action == ipsf_pkg::ACT_CHECK) begin
                  if (!req_item.is_ipv4 || count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{matched: 1'b0, status: ipsf_pkg::ST_CHECKED};
                  end else begin
                     state_in = S_SCAN;
                  end
               end else if (req_item.prefix_length
                            > ipsf_pkg::LEN_W'(ipsf_pkg::FULL_LENGTH)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{matched: 1'b0, status: ipsf_pkg::ST_INVALID};
               end else if (count_ff == '0) begin
                  // empty table: store straight away
                  ram_wr.we    = 1'b1;
                  ram_wr.data  = '{base: start_base, bits: req_item.prefix_length};
                  count_in     = count_ff + 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{matched: 1'b0, status: ipsf_pkg::ST_STORED};
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff && hit) begin
               state_in     = S_IDLE;
               rd_pend_in   = 1'b0;
               rsp_valid_in = 1'b1;
               if (req_ff.action == ipsf_pkg::ACT_CHECK) begin
                  rsp_in = '{matched: 1'b1, status: ipsf_pkg::ST_CHECKED};
               end else begin
                  rsp_in = '{matched: 1'b0, status: ipsf_pkg::ST_DUPLICATE};
               end
            end else if (!issue && !rd_pend_ff) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (req_ff.action == ipsf_pkg::ACT_CHECK) begin
                  rsp_in = '{matched: 1'b0, status: ipsf_pkg::ST_CHECKED};
               end else if (table_full) begin
                  rsp_in = '{matched: 1'b0, status: ipsf_pkg::ST_FULL};
               end else begin
                  ram_wr.we = 1'b1;
                  count_in  = count_ff + 1'b1;
                  rsp_in    = '{matched: 1'b0, status: ipsf_pkg::ST_STORED};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      base_ff   <= base_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // reads stay below the fill count, so no unwritten entry is ever read
   `ASSERT_CLK(a_read_in_range, clock, reset, ram_rd.en |-> (rd_idx_ff < count_ff))
   // fill count never passes the table size
   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= ipsf_pkg::CNT_W'(ipsf_pkg::MAX_ENTRIES))
   // every write is reported as a stored insert in the next cycle
   `ASSERT_CLK(a_write_reported, clock, reset, ram_wr.we |=> (rsp_valid && rsp_item.status == ipsf_pkg::ST_STORED))
   // fill count moves only by a write
   `ASSERT_CLK(a_count_moves_on_write, clock, reset, (count_ff != $past(count_ff)) |-> $past(ram_wr.we))

endmodule
